// ===== hdl/sled_pkg.sv =====
package sled_pkg;

    localparam int SLED_QUEUE_DEPTH = 4;

    localparam int CHAR_W = 21;
    localparam int CP_W   = 32;

    // code points the decoder looks at
    localparam logic [CHAR_W-1:0] CH_QUOTE = 21'h22;
    localparam logic [CHAR_W-1:0] CH_AT    = 21'h40;
    localparam logic [CHAR_W-1:0] CH_BSL   = 21'h5C;
    localparam logic [CHAR_W-1:0] CH_CR    = 21'h0D;
    localparam logic [CHAR_W-1:0] CH_LF    = 21'h0A;
    localparam logic [CHAR_W-1:0] CH_0     = 21'h30;
    localparam logic [CHAR_W-1:0] CH_7     = 21'h37;
    localparam logic [CHAR_W-1:0] CH_9     = 21'h39;
    localparam logic [CHAR_W-1:0] CH_UA    = 21'h41;
    localparam logic [CHAR_W-1:0] CH_UF    = 21'h46;
    localparam logic [CHAR_W-1:0] CH_LA    = 21'h61;
    localparam logic [CHAR_W-1:0] CH_LF_HEX = 21'h66;
    localparam logic [CHAR_W-1:0] CH_UD    = 21'h44;
    localparam logic [CHAR_W-1:0] CH_LD    = 21'h64;
    localparam logic [CHAR_W-1:0] CH_UX    = 21'h58;
    localparam logic [CHAR_W-1:0] CH_LX    = 21'h78;
    localparam logic [CHAR_W-1:0] CH_UU    = 21'h55;
    localparam logic [CHAR_W-1:0] CH_LU    = 21'h75;
    localparam logic [CHAR_W-1:0] CH_LW    = 21'h77;
    localparam logic [CHAR_W-1:0] CH_LB    = 21'h62;
    localparam logic [CHAR_W-1:0] CH_LN    = 21'h6E;
    localparam logic [CHAR_W-1:0] CH_LR    = 21'h72;
    localparam logic [CHAR_W-1:0] CH_LT    = 21'h74;
    localparam logic [CHAR_W-1:0] CH_LV    = 21'h76;

    localparam logic [3:0] UHEX_SHORT = 4'd4;
    localparam logic [3:0] UHEX_LONG  = 4'd8;

    typedef enum logic [3:0] {
        PH_START    = 4'd0,
        PH_PREFIXED = 4'd1,
        PH_AT       = 4'd2,
        PH_VERB     = 4'd3,
        PH_BODY     = 4'd4,
        PH_ESC      = 4'd5,
        PH_HEXRUN   = 4'd6,
        PH_DECRUN   = 4'd7,
        PH_OCTRUN   = 4'd8,
        PH_UHEX     = 4'd9,
        PH_CLOSED   = 4'd10,
        PH_ERROR    = 4'd11
    } phase_t;

    typedef enum logic [1:0] {
        ST_OK           = 2'd0,
        ST_INVALID      = 2'd1,
        ST_HEX_EXPECTED = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        PFX_NONE = 2'd0,
        PFX_W    = 2'd1,
        PFX_U    = 2'd2
    } prefix_t;

    typedef enum logic {
        REC_CHAR = 1'b0,
        REC_END  = 1'b1
    } rec_kind_t;

    // everything one accepted transaction produces, in output order:
    // first code slot, second code slot, end record
    typedef struct packed {
        logic            c0_vld;
        logic [CP_W-1:0] c0;
        logic            c1_vld;
        logic [CP_W-1:0] c1;
        logic            end_vld;
        status_t         status;
        prefix_t         prefix;
    } bundle_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_flags_t;

    function automatic logic [CP_W-1:0] simple_escape(input logic [CHAR_W-1:0] c);
        logic [CP_W-1:0] r;
        r = {{(CP_W-CHAR_W){1'b0}}, c};
        case (c)
            CH_LA:     r = 32'h07;
            CH_LB:     r = 32'h08;
            CH_LF_HEX: r = 32'h0C;
            CH_LN:     r = 32'h0A;
            CH_LR:     r = 32'h0D;
            CH_LT:     r = 32'h09;
            CH_LV:     r = 32'h0B;
            default:   r = {{(CP_W-CHAR_W){1'b0}}, c};
        endcase
        return r;
    endfunction

endpackage

// ===== hdl/sled_front.sv =====
module sled_front
    import sled_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_fire,
    input  logic [CHAR_W-1:0] char_code,
    input  logic              last_char,
    output logic              push,
    output bundle_t           push_data
);

    phase_t          phase_reg, phase_next;
    logic [CP_W-1:0] ev_reg, ev_next;
    logic [3:0]      hd_reg, hd_next;
    prefix_t         pre_reg, pre_next;
    status_t         err_reg, err_next;

    logic            is_hex, is_dec, is_oct;
    logic [3:0]      hex_d;
    logic [3:0]      hd_dec;
    logic            req_a, req_b, req_c, do_body;
    logic [CP_W-1:0] val_a, val_b, val_c;
    status_t         st;
    logic [CP_W-1:0] cz;

    assign cz = {{(CP_W-CHAR_W){1'b0}}, char_code};

    always_comb begin
        is_dec = (char_code >= CH_0) && (char_code <= CH_9);
        is_oct = (char_code >= CH_0) && (char_code <= CH_7);
        is_hex = 1'b1;
        hex_d  = 4'd0;
        if (is_dec) begin
            hex_d = char_code[3:0];
        end else if ((char_code >= CH_UA) && (char_code <= CH_UF)) begin
            hex_d = 4'(char_code[3:0] + 4'd9);
        end else if ((char_code >= CH_LA) && (char_code <= CH_LF_HEX)) begin
            hex_d = 4'(char_code[3:0] + 4'd9);
        end else begin
            is_hex = 1'b0;
        end
    end

    always_comb begin
        phase_next = phase_reg;
        ev_next    = ev_reg;
        hd_next    = hd_reg;
        pre_next   = pre_reg;
        err_next   = err_reg;
        req_a      = 1'b0;
        req_b      = 1'b0;
        req_c      = 1'b0;
        val_a      = '0;
        val_b      = cz;
        val_c      = '0;
        do_body    = 1'b0;
        st         = ST_OK;
        hd_dec     = (hd_reg != 4'd0) ? 4'(hd_reg - 4'd1) : hd_reg;

        case (phase_reg)
            PH_START: begin
                if (char_code == CH_LW) begin
                    pre_next = PFX_W;
                    phase_next = PH_PREFIXED;
                end else if (char_code == CH_LU) begin
                    pre_next = PFX_U;
                    phase_next = PH_PREFIXED;
                end else if (char_code == CH_AT) begin
                    phase_next = PH_AT;
                end else if (char_code == CH_QUOTE) begin
                    phase_next = PH_BODY;
                end else begin
                    err_next = ST_INVALID;
                    phase_next = PH_ERROR;
                end
            end
            PH_PREFIXED: begin
                if (char_code == CH_AT) begin
                    phase_next = PH_AT;
                end else if (char_code == CH_QUOTE) begin
                    phase_next = PH_BODY;
                end else begin
                    err_next = ST_INVALID;
                    phase_next = PH_ERROR;
                end
            end
            PH_AT: begin
                if (char_code == CH_QUOTE) begin
                    phase_next = PH_VERB;
                end else begin
                    err_next = ST_INVALID;
                    phase_next = PH_ERROR;
                end
            end
            PH_VERB: begin
                if (char_code == CH_QUOTE) begin
                    phase_next = PH_CLOSED;
                end else begin
                    req_a = 1'b1;
                    val_a = cz;
                end
            end
            PH_BODY: begin
                do_body = 1'b1;
            end
            PH_ESC: begin
                ev_next = '0;
                if ((char_code == CH_LX) || (char_code == CH_UX)) begin
                    phase_next = PH_HEXRUN;
                end else if ((char_code == CH_LD) || (char_code == CH_UD)) begin
                    phase_next = PH_DECRUN;
                end else if (is_oct) begin
                    ev_next = {{(CP_W-3){1'b0}}, char_code[2:0]};
                    phase_next = PH_OCTRUN;
                end else if (char_code == CH_LU) begin
                    hd_next = UHEX_SHORT;
                    phase_next = PH_UHEX;
                end else if (char_code == CH_UU) begin
                    hd_next = UHEX_LONG;
                    phase_next = PH_UHEX;
                end else begin
                    req_a = 1'b1;
                    val_a = simple_escape(char_code);
                    phase_next = PH_BODY;
                end
            end
            PH_HEXRUN: begin
                if (is_hex) begin
                    ev_next = {ev_reg[CP_W-5:0], hex_d};
                end else begin
                    req_a = 1'b1;
                    val_a = ev_reg;
                    do_body = 1'b1;
                end
            end
            PH_DECRUN: begin
                if (is_dec) begin
                    ev_next = (ev_reg << 3) + (ev_reg << 1)
                              + {{(CP_W-4){1'b0}}, char_code[3:0]};
                end else begin
                    req_a = 1'b1;
                    val_a = ev_reg;
                    do_body = 1'b1;
                end
            end
            PH_OCTRUN: begin
                if (is_oct) begin
                    ev_next = {ev_reg[CP_W-4:0], char_code[2:0]};
                end else begin
                    req_a = 1'b1;
                    val_a = ev_reg;
                    do_body = 1'b1;
                end
            end
            PH_UHEX: begin
                if (is_hex) begin
                    ev_next = {ev_reg[CP_W-5:0], hex_d};
                    hd_next = hd_dec;
                    if (hd_dec == 4'd0) begin
                        req_a = 1'b1;
                        val_a = {ev_reg[CP_W-5:0], hex_d};
                        phase_next = PH_BODY;
                    end
                end else begin
                    err_next = ST_HEX_EXPECTED;
                    phase_next = PH_ERROR;
                end
            end
            PH_CLOSED: begin
                err_next = ST_INVALID;
                phase_next = PH_ERROR;
            end
            default: begin
            end
        endcase

        // plain body text, also the code point that ends a numeric run
        if (do_body) begin
            if (char_code == CH_QUOTE) begin
                phase_next = PH_CLOSED;
            end else if ((char_code == CH_CR) || (char_code == CH_LF)) begin
                err_next = ST_INVALID;
                phase_next = PH_ERROR;
            end else if (char_code == CH_BSL) begin
                phase_next = PH_ESC;
            end else begin
                phase_next = PH_BODY;
                req_b = 1'b1;
            end
        end

        if (last_char) begin
            case (phase_next)
                PH_VERB, PH_BODY, PH_CLOSED: st = ST_OK;
                PH_ESC: begin
                    req_c = 1'b1;
                    val_c = '0;
                end
                PH_HEXRUN, PH_DECRUN, PH_OCTRUN: begin
                    req_c = 1'b1;
                    val_c = ev_next;
                end
                PH_UHEX:  st = ST_HEX_EXPECTED;
                PH_ERROR: st = err_next;
                default:  st = ST_INVALID;
            endcase
        end
    end

    // pack the requests in order into two code slots and the end record
    always_comb begin
        push_data = '0;
        push_data.prefix  = pre_next;
        push_data.status  = st;
        push_data.end_vld = last_char;
        if (req_a) begin
            push_data.c0_vld = 1'b1;
            push_data.c0     = val_a;
            push_data.c1_vld = req_b || req_c;
            push_data.c1     = req_b ? val_b : val_c;
        end else if (req_b) begin
            push_data.c0_vld = 1'b1;
            push_data.c0     = val_b;
            push_data.c1_vld = req_c;
            push_data.c1     = val_c;
        end else begin
            push_data.c0_vld = req_c;
            push_data.c0     = val_c;
        end
        push = in_fire && (push_data.c0_vld || push_data.end_vld);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_START;
            ev_reg    <= '0;
            hd_reg    <= '0;
            pre_reg   <= PFX_NONE;
            err_reg   <= ST_OK;
        end else if (in_fire) begin
            if (last_char) begin
                phase_reg <= PH_START;
                ev_reg    <= '0;
                hd_reg    <= '0;
                pre_reg   <= PFX_NONE;
                err_reg   <= ST_OK;
            end else begin
                phase_reg <= phase_next;
                ev_reg    <= ev_next;
                hd_reg    <= hd_next;
                pre_reg   <= pre_next;
                err_reg   <= err_next;
            end
        end
    end

endmodule

// ===== hdl/sled_queue.sv =====
module sled_queue
    import sled_pkg::*;
#(
    parameter int DEPTH = SLED_QUEUE_DEPTH
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     push,
    input  bundle_t  push_data,
    input  logic     pop,
    output bundle_t  head,
    output q_flags_t flags
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    bundle_t            store_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               do_push, do_pop;

    assign flags.full  = (cnt_reg == CNT_W'(DEPTH));
    assign flags.empty = (cnt_reg == '0);
    assign head        = store_reg[rd_ptr_reg];

    assign do_push = push && !flags.full;
    assign do_pop  = pop && !flags.empty;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(wr_ptr_reg + 1'b1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(rd_ptr_reg + 1'b1);
        end
        if (do_push && !do_pop) begin
            cnt_next = CNT_W'(cnt_reg + 1'b1);
        end else if (do_pop && !do_push) begin
            cnt_next = CNT_W'(cnt_reg - 1'b1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            store_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== hdl/sled_back.sv =====
module sled_back
    import sled_pkg::*;
(
    input  logic            aclk,
    input  logic            aresetn,
    input  bundle_t         head,
    input  q_flags_t        flags,
    output logic            pop,
    output logic            m_valid,
    input  logic            m_ready,
    output logic            m_record_kind,
    output logic [CP_W-1:0] m_code_point,
    output logic [1:0]      m_prefix_kind,
    output logic [1:0]      m_status,
    output logic            m_run_last
);

    logic [1:0] pos_reg, pos_next;
    logic [1:0] n_rec;
    logic       is_end;
    logic       fire;

    assign n_rec = 2'(head.c0_vld) + 2'(head.c1_vld) + 2'(head.end_vld);

    always_comb begin
        is_end       = 1'b0;
        m_code_point = '0;
        case (pos_reg)
            2'd0: begin
                if (head.c0_vld) begin
                    m_code_point = head.c0;
                end else begin
                    is_end = 1'b1;
                end
            end
            2'd1: begin
                if (head.c1_vld) begin
                    m_code_point = head.c1;
                end else begin
                    is_end = 1'b1;
                end
            end
            default: is_end = 1'b1;
        endcase
    end

    assign m_valid       = !flags.empty;
    assign m_record_kind = is_end ? REC_END : REC_CHAR;
    assign m_prefix_kind = head.prefix;
    assign m_status      = is_end ? head.status : ST_OK;
    assign m_run_last    = (pos_reg == 2'(n_rec - 2'd1));

    assign fire = m_valid && m_ready;
    assign pop  = fire && m_run_last;

    always_comb begin
        pos_next = pos_reg;
        if (fire) begin
            pos_next = m_run_last ? 2'd0 : 2'(pos_reg + 2'd1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= 2'd0;
        end else begin
            pos_reg <= pos_next;
        end
    end

endmodule

// ===== hdl/string_literal_escape_decoder_top.sv =====
// string-literal escape decoder
// input channel (s_): one code point of a string-literal token per transaction,
//   s_last_char high on the final code point of the token
// result channel (m_): decoded character records (m_record_kind 0) and one end
//   record per token (m_record_kind 1) carrying the prefix and the status;
//   m_run_last marks the last result caused by one input transaction
// front part classifies every code point in the cycle it is accepted and writes
//   the results it causes (up to three) as one entry into a short queue;
//   back part unrolls the queue head, one result per cycle while m_ready is high
// the first result of a transaction comes from the queue entry registered at acceptance
// throughput: one input transaction per cycle while each causes at most one
//   result and m_ready is high; a transaction with n results drains through the
//   single result port one result at a time, its entry staying at the queue head
// an input that causes no result (quote, backslash, digit of a run) leaves nothing
//   in the queue
// reset clears the token state, the queue and the unroll position
// receiver stall: the head result holds steady on m_; the front keeps accepting
//   until the queue is full, then drops s_ready
module string_literal_escape_decoder_top
    import sled_pkg::*;
#(
    parameter int QUEUE_DEPTH = SLED_QUEUE_DEPTH
) (
    input  logic              aclk,
    input  logic              aresetn,
    // input channel
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [CHAR_W-1:0] s_char_code,
    input  logic              s_last_char,
    // result channel
    output logic              m_valid,
    input  logic              m_ready,
    output logic              m_record_kind,
    output logic [CP_W-1:0]   m_code_point,
    output logic [1:0]        m_prefix_kind,
    output logic [1:0]        m_status,
    output logic              m_run_last
);

    logic     in_fire;
    logic     push;
    bundle_t  push_data;
    logic     pop;
    bundle_t  head;
    q_flags_t flags;

    // accept whenever the queue has room for this transaction's entry
    assign s_ready = !flags.full;
    assign in_fire = s_valid && s_ready;

    // token state machine and escape accumulator
    sled_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_fire   (in_fire),
        .char_code (s_char_code),
        .last_char (s_last_char),
        .push      (push),
        .push_data (push_data)
    );

    // decouples the front from a stalled receiver
    sled_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head      (head),
        .flags     (flags)
    );

    // serializes one queue entry into result transactions
    sled_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .head          (head),
        .flags         (flags),
        .pop           (pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_record_kind (m_record_kind),
        .m_code_point  (m_code_point),
        .m_prefix_kind (m_prefix_kind),
        .m_status      (m_status),
        .m_run_last    (m_run_last)
    );

endmodule

// ===== hdl/sled_checker.sv =====
module sled_checker
    import sled_pkg::*;
(
    input logic              aclk,
    input logic              aresetn,
    input logic              m_valid,
    input logic              m_ready,
    input logic              m_record_kind,
    input logic [CP_W-1:0]   m_code_point,
    input logic [1:0]        m_prefix_kind,
    input logic [1:0]        m_status,
    input logic              m_run_last
);

    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_code_point) && $stable(m_record_kind))
        else $error("result changed while stalled");

    // character records always carry ok status
    a_char_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_record_kind == REC_CHAR) |-> (m_status == ST_OK))
        else $error("status in character record");

    // end record is the last result of its transaction and has no code point
    a_end_rec: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_record_kind == REC_END) |-> m_run_last && (m_code_point == '0))
        else $error("malformed end record");

    // prefix and status stay in their code ranges
    a_codes: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_prefix_kind != 2'd3) && (m_status != 2'd3))
        else $error("prefix or status out of range");

    // nothing is shown right after reset
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind string_literal_escape_decoder_top sled_checker u_sled_checker (.*);
